[hdl/text_row_character_generator_assert.svh]
// Assertion macros used by the character generator RTL.
`ifndef TEXT_ROW_CHARACTER_GENERATOR_ASSERT_SVH
`define TEXT_ROW_CHARACTER_GENERATOR_ASSERT_SVH

// Antecedent in the same cycle implies the consequent.
`define TRCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define TRCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/trcg_pkg.sv]
// Package with constants, font tables and glyph decoding for the character generator.
package trcg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int GLYPH_COUNT = 50;
  localparam int GLYPH_NUM   = GLYPH_COUNT + 1;
  localparam int ROWS        = 7;
  localparam int GLYPH_BITS  = $clog2(GLYPH_NUM);
  localparam int ROW_BITS    = $clog2(ROWS);
  localparam int CFG_BITS    = 12;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [ROW_BITS-1:0]   ROW_LAST    = ROW_BITS'(ROWS - 1);
  localparam logic [GLYPH_BITS-1:0] GLYPH_UNKNOWN = GLYPH_BITS'(GLYPH_COUNT);

  localparam logic [COORD_BITS-1:0] CELL_STEP = COORD_BITS'(6);
  localparam logic [COORD_BITS-1:0] LINE_STEP = COORD_BITS'(9);
  localparam logic [7:0] INK_BRIGHT = 8'd69;
  localparam logic [7:0] INK_DIM    = 8'd32;
  localparam logic [7:0] INK_FLAT   = 8'd15;
  localparam logic [7:0] PAPER_NONE = 8'd255;

  localparam logic [6:0] CODE_NEWLINE = 7'd10;
  localparam logic [6:0] CODE_STAR    = 7'd42;
  localparam logic [6:0] CODE_SPACE   = 7'd32;
  localparam logic [6:0] CODE_PLUS    = 7'd43;
  localparam logic [6:0] CODE_MINUS   = 7'd45;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ORIGIN_X       = 3'd0,
    CFG_ORIGIN_Y       = 3'd1,
    CFG_INK_PLAIN      = 3'd2,
    CFG_PAPER_INDEX    = 3'd3,
    CFG_TEXTURE_SELECT = 3'd4,
    CFG_USE_TEXTURE    = 3'd5
  } cfg_idx_e;

  typedef logic [4:0] glyph_row_t [ROWS];

  localparam glyph_row_t FONT_ROM [GLYPH_NUM] = '{
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31},
    '{5'd1,  5'd1,  5'd1,  5'd1,  5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
    '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    '{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
    '{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
    '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31},
    '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    '{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
    '{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
    '{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
    '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
    '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14},
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12},
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd8},
    '{5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0},
    '{5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd8,  5'd0},
    '{5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd0,  5'd4},
    '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd0,  5'd4},
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31},
    '{5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd0,  5'd0},
    '{5'd2,  5'd4,  5'd8,  5'd8,  5'd8,  5'd4,  5'd2},
    '{5'd8,  5'd4,  5'd2,  5'd2,  5'd2,  5'd4,  5'd8},
    '{5'd4,  5'd4,  5'd2,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd10, 5'd10, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd0,  5'd31, 5'd0,  5'd31, 5'd0,  5'd0,  5'd0},
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd14, 5'd17, 5'd2,  5'd4,  5'd4,  5'd0,  5'd4}
  };

  localparam logic [2:0] SHADE_COL [ROWS] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4};

  typedef logic [7:0] shade_row_t [5];

  localparam shade_row_t SHADE_TABLE [3] = '{
    '{8'd82,  8'd83,  8'd84,  8'd83,  8'd82},
    '{8'd22,  8'd190, 8'd127, 8'd190, 8'd22},
    '{8'd186, 8'd141, 8'd140, 8'd235, 8'd186}
  };

  function automatic logic [6:0] fold_code(input logic [6:0] code);
    logic [6:0] c;
    c = (code == CODE_STAR) ? CODE_SPACE : code;
    if (c >= 7'd97 && c <= 7'd122) begin
      c = c - 7'd32;
    end
    return c;
  endfunction

  function automatic logic [GLYPH_BITS-1:0] glyph_of(input logic [6:0] code);
    logic [GLYPH_BITS-1:0] g;
    g = GLYPH_UNKNOWN;
    if (code >= 7'd65 && code <= 7'd90) begin
      g = GLYPH_BITS'(code - 7'd65);
    end else if (code >= 7'd48 && code <= 7'd57) begin
      g = GLYPH_BITS'(code - 7'd48 + 7'd26);
    end else begin
      case (code)
        7'd46:   g = GLYPH_BITS'(36);
        7'd44:   g = GLYPH_BITS'(37);
        7'd58:   g = GLYPH_BITS'(38);
        7'd59:   g = GLYPH_BITS'(39);
        7'd33:   g = GLYPH_BITS'(40);
        7'd63:   g = GLYPH_BITS'(41);
        7'd95:   g = GLYPH_BITS'(42);
        7'd47:   g = GLYPH_BITS'(43);
        7'd40:   g = GLYPH_BITS'(44);
        7'd41:   g = GLYPH_BITS'(45);
        7'd39:   g = GLYPH_BITS'(46);
        7'd34:   g = GLYPH_BITS'(47);
        7'd61:   g = GLYPH_BITS'(48);
        7'd32:   g = GLYPH_BITS'(49);
        default: g = GLYPH_UNKNOWN;
      endcase
    end
    return g;
  endfunction

endpackage

[hdl/text_row_character_generator.sv]
// Top level of the 5x7 text row character generator.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   char_code_i, run_start_i, clear_markers_i
//   output   out        out_valid_o / out_stall_i pixel_x_o .. last_row_o
//   config   in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A drawn character gives one glyph row per unstalled cycle out of the synchronous font ROM.
// A newline, '+' or '-' produces no row.
// The next request is taken in the cycle the last row of the current character is issued.
// Reset clears the cursor, the markers, the row sequencer and restores register defaults.
// A stall on the output holds the output register and the row sequencer in place.
module text_row_character_generator
  import trcg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [6:0]              char_code_i,
  input  logic                    run_start_i,
  input  logic                    clear_markers_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COORD_BITS-1:0]   pixel_x_o,
  output logic [COORD_BITS-1:0]   pixel_y_o,
  output logic [ROW_BITS-1:0]     row_index_o,
  output logic [4:0]              row_bits_o,
  output logic [7:0]              ink_index_o,
  output logic                    paper_fill_o,
  output logic                    last_row_o
);

`include "text_row_character_generator_assert.svh"

  logic [COORD_BITS-1:0] origin_x_q, origin_y_q;
  logic [7:0]            ink_plain_q, paper_index_q;
  logic [1:0]            texture_select_q;
  logic                  use_texture_q;

  logic [COORD_BITS-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic                  bright_q, bright_d, dim_q, dim_d;

  logic                  active_q, active_d;
  logic [ROW_BITS-1:0]   rcnt_q, rcnt_d;
  logic [GLYPH_BITS-1:0] job_glyph_q;
  logic [COORD_BITS-1:0] job_x_q, job_y_q;
  logic                  job_bright_q, job_dim_q;

  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [ROW_BITS-1:0]   out_row_q;
  logic [4:0]            out_bits_q;
  logic [7:0]            out_ink_q;
  logic                  out_paper_q, out_last_q;

  logic                  advance, issue, finishing, in_acc, draw;
  logic [6:0]            code;
  logic [COORD_BITS-1:0] cx, cy;
  logic                  mb, md;
  logic [7:0]            row_ink;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q       <= '0;
      origin_y_q       <= '0;
      ink_plain_q      <= 8'd15;
      paper_index_q    <= 8'd255;
      texture_select_q <= '0;
      use_texture_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X:       origin_x_q       <= cfg_data_i[COORD_BITS-1:0];
        CFG_ORIGIN_Y:       origin_y_q       <= cfg_data_i[COORD_BITS-1:0];
        CFG_INK_PLAIN:      ink_plain_q      <= cfg_data_i[7:0];
        CFG_PAPER_INDEX:    paper_index_q    <= cfg_data_i[7:0];
        CFG_TEXTURE_SELECT: texture_select_q <= cfg_data_i[1:0];
        CFG_USE_TEXTURE:    use_texture_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign advance   = !out_valid_q || !out_stall_i;
  assign issue     = active_q && advance;
  assign finishing = issue && (rcnt_q == ROW_LAST);
  assign in_stall_o = active_q && !finishing;
  assign in_acc    = in_valid_i && !in_stall_o;

  assign code = fold_code(char_code_i);
  assign draw = (code != CODE_NEWLINE) && (code != CODE_PLUS) && (code != CODE_MINUS);

  always_comb begin
    cx = run_start_i ? origin_x_q : cursor_x_q;
    cy = run_start_i ? origin_y_q : cursor_y_q;
    mb = clear_markers_i ? 1'b0 : bright_q;
    md = clear_markers_i ? 1'b0 : dim_q;
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    bright_d   = bright_q;
    dim_d      = dim_q;
    if (in_acc) begin
      cursor_y_d = cy;
      bright_d   = mb;
      dim_d      = md;
      if (code == CODE_NEWLINE) begin
        cursor_x_d = origin_x_q;
        cursor_y_d = cy + LINE_STEP;
      end else begin
        cursor_x_d = cx + CELL_STEP;
        if (code == CODE_PLUS) begin
          bright_d = !mb;
        end else if (code == CODE_MINUS) begin
          dim_d = !md;
        end
      end
    end
  end

  always_comb begin
    active_d = active_q;
    rcnt_d   = rcnt_q;
    if (issue) begin
      rcnt_d = finishing ? '0 : rcnt_q + ROW_BITS'(1);
      if (finishing) begin
        active_d = 1'b0;
      end
    end
    if (in_acc && draw) begin
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      bright_q    <= 1'b0;
      dim_q       <= 1'b0;
      active_q    <= 1'b0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      bright_q   <= bright_d;
      dim_q      <= dim_d;
      active_q   <= active_d;
      rcnt_q     <= rcnt_d;
      if (advance) begin
        out_valid_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && draw) begin
      job_glyph_q  <= glyph_of(code);
      job_x_q      <= cx;
      job_y_q      <= cy;
      job_bright_q <= mb;
      job_dim_q    <= md;
    end
  end

  always_comb begin
    if (job_bright_q) begin
      row_ink = INK_BRIGHT;
    end else if (job_dim_q) begin
      row_ink = INK_DIM;
    end else if (use_texture_q) begin
      if (texture_select_q == 2'd0) begin
        row_ink = INK_FLAT;
      end else begin
        row_ink = SHADE_TABLE[texture_select_q - 2'd1][SHADE_COL[rcnt_q]];
      end
    end else begin
      row_ink = ink_plain_q;
    end
  end

  // The font ROM read is registered straight into the output stage.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_bits_q  <= FONT_ROM[job_glyph_q][rcnt_q];
      out_x_q     <= job_x_q;
      out_y_q     <= job_y_q + COORD_BITS'(rcnt_q);
      out_row_q   <= rcnt_q;
      out_ink_q   <= row_ink;
      out_paper_q <= (paper_index_q != PAPER_NONE);
      out_last_q  <= (rcnt_q == ROW_LAST);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_y_o    = out_y_q;
  assign row_index_o  = out_row_q;
  assign row_bits_o   = out_bits_q;
  assign ink_index_o  = out_ink_q;
  assign paper_fill_o = out_paper_q;
  assign last_row_o   = out_last_q;

  `TRCG_ASSERT_IMP(a_idle_count, clk_i, rst_ni, !active_q, rcnt_q == '0, "row count not reset while idle")
  `TRCG_ASSERT_NEXT(a_draw_starts, clk_i, rst_ni, in_acc && draw, active_q && rcnt_q == '0, "drawn character did not start at row zero")
  `TRCG_ASSERT_NEXT(a_row_follows, clk_i, rst_ni, out_valid_q && !out_stall_i && !out_last_q, out_valid_q && out_row_q == $past(out_row_q) + ROW_BITS'(1), "glyph rows out of sequence")

endmodule
